### rtl/lz77_pkg.sv
package lz77_pkg;

   localparam int unsigned WINDOW_SIZE   = 4096;
   localparam int unsigned MIN_MATCH_LEN = 3;
   localparam int unsigned MAX_RESULTS   = 64;

   localparam int unsigned ADDR_W = $clog2(WINDOW_SIZE);
   localparam int unsigned LEN_W  = $clog2(MAX_RESULTS + 1);

   typedef logic [1:0] status_type;
   localparam status_type ST_OK       = 2'd0;
   localparam status_type ST_BAD_REF  = 2'd1;
   localparam status_type ST_OVER_CAP = 2'd2;

   localparam logic TOK_LITERAL = 1'b0;
   localparam logic TOK_REF     = 1'b1;

   // controller -> datapath
   typedef struct packed {
      logic accept;     // latch the request
      logic check;      // update sticky error, load copy length
      logic emit_err;   // error result
      logic emit_lit;   // literal result
      logic rd;         // window read for the next copy byte
      logic emit_copy;  // copied byte result
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic err_nz;     // error pending for the request under check
      logic is_ref;
      logic out_free;   // output register can take a result
      logic copy_last;  // one copy byte left
   } stat_type;

endpackage

### rtl/lz77_ram.sv
module lz77_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/lz77_ctrl.sv
module lz77_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  lz77_pkg::stat_type stat,
   output lz77_pkg::cmd_type  cmd
);

   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_CHECK = 6'b000010,
      S_ERR   = 6'b000100,
      S_LIT   = 6'b001000,
      S_READ  = 6'b010000,
      S_COPY  = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = S_CHECK;
            end
         end
         S_CHECK: begin
            cmd.check = 1'b1;
            if (stat.err_nz) begin
               state_in = S_ERR;
            end else if (stat.is_ref) begin
               state_in = S_READ;
            end else begin
               state_in = S_LIT;
            end
         end
         S_ERR: begin
            if (stat.out_free) begin
               cmd.emit_err = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_LIT: begin
            if (stat.out_free) begin
               cmd.emit_lit = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_READ: begin
            cmd.rd   = 1'b1;
            state_in = S_COPY;
         end
         S_COPY: begin
            if (stat.out_free) begin
               cmd.emit_copy = 1'b1;
               state_in      = stat.copy_last ? S_IDLE : S_READ;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign req_stall = (state_ff != S_IDLE);

endmodule

### rtl/lz77_dp.sv
module lz77_dp (
   input  logic                  clock,
   input  logic                  reset,
   input  lz77_pkg::cmd_type     cmd,
   output lz77_pkg::stat_type    stat,
   input  logic                  req_type,
   input  logic [7:0]            req_literal_byte,
   input  logic [15:0]           req_distance,
   input  logic [5:0]            req_length_code,
   input  logic                  req_last_token,
   input  logic                  csr_wr_en,
   input  logic [31:0]           csr_wr_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [7:0]            rsp_out_byte,
   output logic [31:0]           rsp_produced_count,
   output lz77_pkg::status_type  rsp_status,
   output logic                  rsp_last_of_run
);

   localparam int unsigned AW = lz77_pkg::ADDR_W;
   localparam int unsigned LW = lz77_pkg::LEN_W;

   // latched request
   logic        tok_type_ff;
   logic [7:0]  tok_lit_ff;
   logic [15:0] tok_dist_ff;
   logic [5:0]  tok_code_ff;
   logic        tok_last_ff;

   logic [31:0]          cap_ff;
   logic [31:0]          count_ff, count_in;
   lz77_pkg::status_type err_ff, err_in;
   logic [LW-1:0]        remain_ff, remain_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [7:0]           out_byte_ff, out_byte_in;
   logic [31:0]          out_count_ff, out_count_in;
   lz77_pkg::status_type out_status_ff, out_status_in;
   logic                 out_last_ff, out_last_in;

   logic [LW-1:0]        ref_len, tok_len;
   logic                 bad_ref, over_cap;
   lz77_pkg::status_type err_check;
   logic [31:0]          count_inc;
   logic [31:0]          src_pos;
   logic [7:0]           ram_rd_data;
   logic                 ram_wr_en;
   logic [7:0]           ram_wr_data;
   logic                 final_emit;

   always_comb begin
      ref_len = LW'(tok_code_ff) + LW'(lz77_pkg::MIN_MATCH_LEN);
      if (ref_len > LW'(lz77_pkg::MAX_RESULTS)) begin
         ref_len = LW'(lz77_pkg::MAX_RESULTS);
      end
      tok_len = (tok_type_ff == lz77_pkg::TOK_REF) ? ref_len : LW'(1);

      bad_ref = (tok_dist_ff == 16'd0) || (32'(tok_dist_ff) > count_ff)
             || (17'(tok_dist_ff) > 17'(lz77_pkg::WINDOW_SIZE));
      over_cap = (33'(count_ff) + 33'(tok_len)) > 33'(cap_ff);

      if (err_ff != lz77_pkg::ST_OK) begin
         err_check = err_ff;
      end else if ((tok_type_ff == lz77_pkg::TOK_REF) && bad_ref) begin
         err_check = lz77_pkg::ST_BAD_REF;
      end else if (over_cap) begin
         err_check = lz77_pkg::ST_OVER_CAP;
      end else begin
         err_check = lz77_pkg::ST_OK;
      end
   end

   assign count_inc = count_ff + 32'd1;
   assign src_pos   = count_ff - 32'(tok_dist_ff);

   assign stat.err_nz    = (err_check != lz77_pkg::ST_OK);
   assign stat.is_ref    = (tok_type_ff == lz77_pkg::TOK_REF);
   assign stat.out_free  = !rsp_valid_ff || !rsp_stall;
   assign stat.copy_last = (remain_ff == LW'(1));

   assign final_emit = cmd.emit_lit || (cmd.emit_copy && stat.copy_last);

   always_comb begin
      count_in  = count_ff;
      err_in    = err_ff;
      remain_in = remain_ff;

      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      out_byte_in   = out_byte_ff;
      out_count_in  = out_count_ff;
      out_status_in = out_status_ff;
      out_last_in   = out_last_ff;

      if (cmd.check) begin
         err_in    = err_check;
         remain_in = tok_len;
      end

      if (cmd.emit_err) begin
         rsp_valid_in  = 1'b1;
         out_byte_in   = 8'd0;
         out_count_in  = count_ff;
         out_status_in = err_ff;
         out_last_in   = 1'b1;
         if (tok_last_ff) begin
            count_in = '0;
            err_in   = lz77_pkg::ST_OK;
         end
      end

      if (cmd.emit_lit || cmd.emit_copy) begin
         rsp_valid_in  = 1'b1;
         out_byte_in   = ram_wr_data;
         out_count_in  = count_inc;
         out_status_in = lz77_pkg::ST_OK;
         out_last_in   = final_emit;
         count_in      = (final_emit && tok_last_ff) ? 32'd0 : count_inc;
         remain_in     = remain_ff - LW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff       <= '1;
         count_ff     <= '0;
         err_ff       <= lz77_pkg::ST_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            cap_ff <= csr_wr_data;
         end
         count_ff     <= count_in;
         err_ff       <= err_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         tok_type_ff <= req_type;
         tok_lit_ff  <= req_literal_byte;
         tok_dist_ff <= req_distance;
         tok_code_ff <= req_length_code;
         tok_last_ff <= req_last_token;
      end
      remain_ff     <= remain_in;
      out_byte_ff   <= out_byte_in;
      out_count_ff  <= out_count_in;
      out_status_ff <= out_status_in;
      out_last_ff   <= out_last_in;
   end

   // every emitted byte goes into the window at its stream position
   assign ram_wr_en   = cmd.emit_lit || cmd.emit_copy;
   assign ram_wr_data = cmd.emit_lit ? tok_lit_ff : ram_rd_data;

   lz77_ram #(
      .WIDTH (8),
      .DEPTH (lz77_pkg::WINDOW_SIZE)
   ) u_window (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (ram_wr_data),
      .rd_en   (cmd.rd),
      .rd_addr (src_pos[AW-1:0]),
      .rd_data (ram_rd_data)
   );

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_out_byte       = out_byte_ff;
   assign rsp_produced_count = out_count_ff;
   assign rsp_status         = out_status_ff;
   assign rsp_last_of_run    = out_last_ff;

endmodule

### rtl/lz77_token_decoder.sv
// A request is taken in IDLE and checked in CHECK. A literal or error result is
// then registered from LIT or ERR; a back reference runs READ then COPY per byte.
// One request at a time; LIT, ERR and COPY wait while the output is stalled.
// Each copied byte needs a window read and a registered read-out before it is
// written back and sent.
// Reset (synchronous): byte count, error status cleared, capacity all ones.
module lz77_token_decoder (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_type,
   input  logic [7:0]           req_literal_byte,
   input  logic [15:0]          req_distance,
   input  logic [5:0]           req_length_code,
   input  logic                 req_last_token,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [7:0]           rsp_out_byte,
   output logic [31:0]          rsp_produced_count,
   output logic [1:0]           rsp_status,
   output logic                 rsp_last_of_run,
   input  logic                 csr_wr_en,
   input  logic [31:0]          csr_wr_data
);

   lz77_pkg::cmd_type  cmd;
   lz77_pkg::stat_type stat;

   lz77_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   lz77_dp u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .stat               (stat),
      .req_type           (req_type),
      .req_literal_byte   (req_literal_byte),
      .req_distance       (req_distance),
      .req_length_code    (req_length_code),
      .req_last_token     (req_last_token),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_out_byte       (rsp_out_byte),
      .rsp_produced_count (rsp_produced_count),
      .rsp_status         (rsp_status),
      .rsp_last_of_run    (rsp_last_of_run)
   );

   // error results are single, empty and close their request
   a_err_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != lz77_pkg::ST_OK)
      |-> (rsp_out_byte == 8'd0) && rsp_last_of_run)
      else $error("error result with data or without last flag");

   // no new request while a copy is still under way
   a_mid_copy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_of_run |-> req_stall)
      else $error("request taken in the middle of a copy");

   // one request in flight at a time
   a_one_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("back-to-back requests taken");

endmodule

### tb/sv/testbench.sv
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int PERIOD     = 10;
   localparam int IDLE_LIMIT = 2000;
   localparam int MAX_WAIT   = 18;

   typedef struct {
      logic        kind;
      logic [7:0]  lit;
      logic [15:0] offset;
      logic [5:0]  code;
      logic        last;
      bit          hold;   // sender waits for every outstanding byte first
   } token_type;

   typedef struct {
      logic [7:0]           data;
      logic [31:0]          count;
      lz77_pkg::status_type status;
      logic                 last;
   } decoded_type;

   logic        clock              = 1'b0;
   logic        reset              = 1'b1;
   logic        req_valid          = 1'b0;
   logic        req_stall;
   logic        req_type           = lz77_pkg::TOK_LITERAL;
   logic [7:0]  req_literal_byte   = '0;
   logic [15:0] req_distance       = '0;
   logic [5:0]  req_length_code    = '0;
   logic        req_last_token     = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall          = 1'b0;
   logic [7:0]  rsp_out_byte;
   logic [31:0] rsp_produced_count;
   logic [1:0]  rsp_status;
   logic        rsp_last_of_run;
   logic        csr_wr_en          = 1'b0;
   logic [31:0] csr_wr_data        = '0;

   lz77_token_decoder dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_type           (req_type),
      .req_literal_byte   (req_literal_byte),
      .req_distance       (req_distance),
      .req_length_code    (req_length_code),
      .req_last_token     (req_last_token),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_out_byte       (rsp_out_byte),
      .rsp_produced_count (rsp_produced_count),
      .rsp_status         (rsp_status),
      .rsp_last_of_run    (rsp_last_of_run),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data)
   );

   always #(PERIOD / 2) clock = ~clock;

   token_type   token_q[$];
   decoded_type decoded_q[$];
   token_type   cur_tok;
   int          mismatches = 0;
   int          tx_gap     = 0;
   int          rx_wait    = 0;
   int          idle_cycles = 0;
   bit          tx_calm    = 1'b0;
   bit          rx_calm    = 1'b0;

   // decoder state as the block should hold it
   logic [7:0]           hist [lz77_pkg::WINDOW_SIZE];
   logic [31:0]          stream_count  = '0;
   lz77_pkg::status_type sticky_status = lz77_pkg::ST_OK;
   logic [31:0]          capacity      = '1;

   task automatic decode_token(input token_type t);
      int unsigned len;
      logic [31:0] back;
      logic [7:0]  b;
      decoded_type d;
      len = 1;
      if (sticky_status == lz77_pkg::ST_OK) begin
         if (t.kind == lz77_pkg::TOK_REF) begin
            len = int'(t.code) + lz77_pkg::MIN_MATCH_LEN;
            if (len > lz77_pkg::MAX_RESULTS)
               len = lz77_pkg::MAX_RESULTS;
            if (t.offset == 0 || t.offset > stream_count
                || t.offset > lz77_pkg::WINDOW_SIZE)
               sticky_status = lz77_pkg::ST_BAD_REF;
         end
         if (sticky_status == lz77_pkg::ST_OK &&
             64'(stream_count) + 64'(len) > 64'(capacity))
            sticky_status = lz77_pkg::ST_OVER_CAP;
      end
      if (sticky_status != lz77_pkg::ST_OK) begin
         d = '{data: 8'd0, count: stream_count, status: sticky_status, last: 1'b1};
         decoded_q.push_back(d);
      end else if (t.kind == lz77_pkg::TOK_LITERAL) begin
         hist[stream_count[lz77_pkg::ADDR_W-1:0]] = t.lit;
         stream_count++;
         d = '{data: t.lit, count: stream_count, status: lz77_pkg::ST_OK, last: 1'b1};
         decoded_q.push_back(d);
      end else begin
         // byte by byte so an overlapping copy sees its own output
         for (int unsigned k = 0; k < len; k++) begin
            back = stream_count - 32'(t.offset);
            b = hist[back[lz77_pkg::ADDR_W-1:0]];
            hist[stream_count[lz77_pkg::ADDR_W-1:0]] = b;
            stream_count++;
            d = '{data: b, count: stream_count, status: lz77_pkg::ST_OK,
                  last: (k + 1 == len)};
            decoded_q.push_back(d);
         end
      end
      if (t.last) begin
         stream_count  = '0;
         sticky_status = lz77_pkg::ST_OK;
      end
   endtask

   task automatic check_field(input string name, input longint unsigned want,
                              input longint unsigned got);
      if (want != got) begin
         mismatches++;
         $display("%0t: %s expected %0h got %0h", $time, name, want, got);
      end
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         tx_gap = 0;
      end else begin
         if (req_valid && !req_stall)
            decode_token(cur_tok);
         if (!req_valid || !req_stall) begin
            if (token_q.size() == 0 || (token_q[0].hold && decoded_q.size() != 0)) begin
               req_valid <= 1'b0;
            end else if (tx_gap > 0) begin
               tx_gap--;
               req_valid <= 1'b0;
            end else begin
               cur_tok = token_q.pop_front();
               req_type         <= cur_tok.kind;
               req_literal_byte <= cur_tok.lit;
               req_distance     <= cur_tok.offset;
               req_length_code  <= cur_tok.code;
               req_last_token   <= cur_tok.last;
               req_valid        <= 1'b1;
               tx_gap = tx_calm ? 0 : $urandom_range(0, MAX_WAIT);
            end
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      decoded_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
         rx_wait = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (decoded_q.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected result byte %0h count %0d status %0d last %0b",
                        $time, rsp_out_byte, rsp_produced_count, rsp_status,
                        rsp_last_of_run);
            end else begin
               want = decoded_q.pop_front();
               check_field("out_byte", want.data, rsp_out_byte);
               check_field("produced_count", want.count, rsp_produced_count);
               check_field("status", want.status, rsp_status);
               check_field("last_of_run", want.last, rsp_last_of_run);
            end
            rx_wait = rx_calm ? 0 : $urandom_range(0, MAX_WAIT);
         end
         if (rx_wait > 0) begin
            rx_wait--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("testbench: FAIL");
         $finish;
      end
   end

   task automatic push_tok(input logic kind, input logic [7:0] lit, input logic [15:0] offset,
                           input logic [5:0] code, input logic last, input bit hold);
      token_type t;
      t = '{kind: kind, lit: lit, offset: offset, code: code, last: last, hold: hold};
      token_q.push_back(t);
   endtask

   task automatic wait_idle();
      while (token_q.size() != 0 || req_valid || decoded_q.size() != 0)
         @(posedge clock);
   endtask

   task automatic set_capacity(input logic [31:0] cap);
      wait_idle();
      repeat (4) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= cap;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      capacity = cap;
   endtask

   // One stream of tokens, mostly sound references into what has been produced.
   // Long mode: no noise, long copies, no end marker (caller closes the stream).
   task automatic gen_stream(input int n, input bit long_mode);
      token_type   t;
      int unsigned est;
      int unsigned lim;
      int unsigned r;
      est = 0;
      for (int i = 0; i < n; i++) begin
         t.lit    = 8'($urandom_range(0, 255));
         t.offset = 16'($urandom_range(0, 65535));
         t.code   = 6'($urandom_range(0, 61));
         t.hold   = ($urandom_range(0, 49) == 0);
         t.last   = 1'b0;
         r = $urandom_range(0, 99);
         if (est == 0 || r < (long_mode ? 10 : 25)) begin
            t.kind = lz77_pkg::TOK_LITERAL;
         end else begin
            t.kind = lz77_pkg::TOK_REF;
            lim = (est > lz77_pkg::WINDOW_SIZE) ? lz77_pkg::WINDOW_SIZE : est;
            if (long_mode || r < 90)
               t.offset = 16'($urandom_range(1, lim));
            else if (r < 93)
               t.offset = 16'(lim);
            else if (r < 96)
               t.offset = 16'(lim + 1);
            if (long_mode)
               t.code = 6'($urandom_range(40, 61));
            else if ($urandom_range(0, 3) != 0)
               t.code = 6'($urandom_range(0, 7));
         end
         est += (t.kind == lz77_pkg::TOK_LITERAL) ? 1
                : int'(t.code) + lz77_pkg::MIN_MATCH_LEN;
         if (!long_mode && (i == n - 1 || $urandom_range(0, 99) < 3)) begin
            t.last = 1'b1;
            est = 0;
         end
         token_q.push_back(t);
      end
   endtask

   task automatic random_phase(input logic [31:0] cap, input int n);
      int queued;
      int len;
      set_capacity(cap);
      tx_calm = ($urandom_range(0, 3) == 0);
      rx_calm = ($urandom_range(0, 3) == 0);
      queued = 0;
      while (queued < n) begin
         len = $urandom_range(1, 24);
         gen_stream(len, 1'b0);
         queued += len;
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      set_capacity(32'hFFFF_FFFF);
      tx_calm = 1'b0;
      rx_calm = 1'b0;
      // bad reference on an empty stream, then sticky until the end marker
      push_tok(lz77_pkg::TOK_REF,     8'h00, 16'd0,     6'd0,  1'b0, 1'b0);
      push_tok(lz77_pkg::TOK_LITERAL, 8'h11, 16'd0,     6'd0,  1'b0, 1'b0);
      push_tok(lz77_pkg::TOK_LITERAL, 8'h22, 16'hFFFF,  6'h3F, 1'b1, 1'b0);
      push_tok(lz77_pkg::TOK_LITERAL, 8'h00, 16'd0,     6'd0,  1'b0, 1'b0);
      push_tok(lz77_pkg::TOK_LITERAL, 8'hFF, 16'd0,     6'd0,  1'b0, 1'b0);
      push_tok(lz77_pkg::TOK_LITERAL, 8'hA5, 16'd0,     6'd0,  1'b0, 1'b0);
      // overlapping copy, longest legal copy, saturated length
      push_tok(lz77_pkg::TOK_REF,     8'h00, 16'd1,     6'd0,  1'b0, 1'b0);
      push_tok(lz77_pkg::TOK_REF,     8'h00, 16'd6,     6'd61, 1'b0, 1'b0);
      push_tok(lz77_pkg::TOK_REF,     8'h00, 16'd70,    6'd63, 1'b0, 1'b1);
      // one beyond what has been produced
      push_tok(lz77_pkg::TOK_REF,     8'h00, 16'd135,   6'd2,  1'b0, 1'b0);
      push_tok(lz77_pkg::TOK_LITERAL, 8'h3C, 16'd0,     6'd0,  1'b1, 1'b0);
      push_tok(lz77_pkg::TOK_LITERAL, 8'h5A, 16'd0,     6'd0,  1'b1, 1'b0);
      push_tok(lz77_pkg::TOK_LITERAL, 8'h81, 16'd0,     6'd0,  1'b0, 1'b0);
      push_tok(lz77_pkg::TOK_REF,     8'h00, 16'hFFFF,  6'd5,  1'b1, 1'b0);
      push_tok(lz77_pkg::TOK_LITERAL, 8'h7E, 16'd0,     6'd0,  1'b0, 1'b0);
      push_tok(lz77_pkg::TOK_REF,     8'h00, 16'd1,     6'd61, 1'b1, 1'b0);

      set_capacity(32'd0);
      push_tok(lz77_pkg::TOK_LITERAL, 8'h01, 16'd0,     6'd0,  1'b0, 1'b0);
      push_tok(lz77_pkg::TOK_REF,     8'h00, 16'd0,     6'd0,  1'b1, 1'b0);

      set_capacity(32'd5);
      push_tok(lz77_pkg::TOK_LITERAL, 8'h10, 16'd0,     6'd0,  1'b0, 1'b0);
      push_tok(lz77_pkg::TOK_LITERAL, 8'h20, 16'd0,     6'd0,  1'b0, 1'b0);
      push_tok(lz77_pkg::TOK_LITERAL, 8'h30, 16'd0,     6'd0,  1'b0, 1'b0);
      push_tok(lz77_pkg::TOK_REF,     8'h00, 16'd3,     6'd0,  1'b1, 1'b0);
      push_tok(lz77_pkg::TOK_LITERAL, 8'h40, 16'd0,     6'd0,  1'b0, 1'b0);
      push_tok(lz77_pkg::TOK_REF,     8'h00, 16'd1,     6'd0,  1'b0, 1'b0);
      push_tok(lz77_pkg::TOK_LITERAL, 8'h50, 16'd0,     6'd0,  1'b0, 1'b0);
      push_tok(lz77_pkg::TOK_LITERAL, 8'h60, 16'd0,     6'd0,  1'b1, 1'b0);

      random_phase(32'hFFFF_FFFF, 40);
      random_phase(32'($urandom_range(20, 400)), 40);
      random_phase(32'd1, 40);

      // stream longer than the window so copies wrap round it
      set_capacity(32'hFFFF_FFFF);
      tx_calm = ($urandom_range(0, 1) == 0);
      rx_calm = ($urandom_range(0, 1) == 0);
      gen_stream(140, 1'b1);
      push_tok(lz77_pkg::TOK_REF, 8'h00, 16'(lz77_pkg::WINDOW_SIZE),     6'd0, 1'b0, 1'b0);
      push_tok(lz77_pkg::TOK_REF, 8'h00, 16'(lz77_pkg::WINDOW_SIZE + 1), 6'd0, 1'b1, 1'b0);

      random_phase($urandom, 40);

      wait_idle();
      repeat (20) @(posedge clock);
      if (decoded_q.size() != 0) begin
         mismatches++;
         $display("%0t: %0d expected results never arrived", $time, decoded_q.size());
      end
      if (mismatches == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end

endmodule
